@@ rtl/core/lrsa_pkg.sv @@
// ---------------------------------------------------------------------------
// lrsa_pkg: shared types and constants of the log record slot allocator
// Payload structs, cursor state, register indexes and the derived
// page geometry used by the allocator core.
// ---------------------------------------------------------------------------
`default_nettype none

package lrsa_pkg;

	// record layout constants
	localparam int unsigned FIRST_SLOT   = 'h40;
	localparam int unsigned HDR_LEN      = 'h30;
	localparam int unsigned PAYLOAD_BASE = 'h50;
	localparam int unsigned SEQ_BASE     = 67;

	// register reset values
	localparam logic [3:0]  PAGE_SHIFT_RST = 4'd12;
	localparam logic [15:0] PAGE_COUNT_RST = 16'd1024;
	localparam logic [3:0]  PAGE_SHIFT_MIN = 4'd9;
	localparam logic [15:0] PAGE_COUNT_MIN = 16'd4;

	// cursor reset values
	localparam logic [15:0] CURSOR_PAGE_RST = 16'd2;
	localparam logic [15:0] CURSOR_OFF_RST  = 16'd64;
	localparam logic [63:0] SEQ_RST         = 64'd1;

	// configuration port
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAGE_SHIFT = 1'b0,
		REG_PAGE_COUNT = 1'b1
	} reg_index_t;

	// status codes
	typedef enum logic {
		ST_PLACED   = 1'b0,
		ST_LOG_FULL = 1'b1
	} status_t;

	typedef struct packed {
		logic [15:0] redo_length;
		logic [15:0] undo_length;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] lsn;
		logic [31:0] record_offset;
		logic [17:0] client_data_length;
		logic [16:0] undo_start;
		logic [17:0] total_length;
		logic        wrapped;
	} rsp_t;

	// effective page geometry after clamping to the minimums
	typedef struct packed {
		logic [3:0]  shift;
		logic [15:0] count;
		logic [4:0]  obits;
	} cfg_t;

	typedef struct packed {
		logic [15:0] page;
		logic [15:0] off;
		logic [63:0] seq;
	} state_t;

	// record geometry for one request
	typedef struct packed {
		logic [16:0] uoff;
		logic [17:0] cdl;
		logic [17:0] total;
		logic        full;
	} geom_t;

	// placement result for one accepted record
	typedef struct packed {
		logic [63:0] lsn;
		logic [31:0] byte_off;
		logic        wrapped;
	} place_t;

	// clamp the registers and work out the offset bit count of the LSN
	function automatic cfg_t derive_cfg(logic [3:0] shift_raw, logic [15:0] count_raw);
		cfg_t        c;
		logic [4:0]  bl;
		bl = 5'd0;
		c.shift = (shift_raw < PAGE_SHIFT_MIN) ? PAGE_SHIFT_MIN : shift_raw;
		c.count = (count_raw < PAGE_COUNT_MIN) ? PAGE_COUNT_MIN : count_raw;
		for (int i = 0; i < 16; i++) begin
			if (c.count[i]) begin
				bl = 5'(i + 1);
			end
		end
		// bit length of the image size is bl + shift; offset bits are that minus 3
		c.obits = 5'(bl + {1'b0, c.shift} - 5'd3);
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/lrsa_stream_if.sv @@
// ---------------------------------------------------------------------------
// lrsa_stream_if: valid/ready stream channel
// Carries one payload per transfer; a transfer happens on a rising edge
// with valid and ready both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface lrsa_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lrsa_geometry.sv @@
// ---------------------------------------------------------------------------
// lrsa_geometry: record geometry of one request
// Undo offset, client data length, aligned total length and the
// larger-than-a-page check.
// ---------------------------------------------------------------------------
`default_nettype none

module lrsa_geometry (
	input  wire lrsa_pkg::req_t  req,
	input  wire lrsa_pkg::cfg_t  cfg,
	output lrsa_pkg::geom_t      geom
);

	logic [16:0] uoff_sum;
	logic [17:0] cdl;
	logic [17:0] total_sum;
	logic [18:0] psize;
	logic [18:0] limit;

	// undo offset: align8(0x50 + redo)
	assign uoff_sum = {1'b0, req.redo_length} + 17'(lrsa_pkg::PAYLOAD_BASE + 7);

	// client data: undo offset past the header, plus undo bytes
	assign cdl = {1'b0, uoff_sum[16:3], 3'b000} - 18'(lrsa_pkg::HDR_LEN)
		+ {2'b00, req.undo_length};

	// total: align8(header + client data)
	assign total_sum = cdl + 18'(lrsa_pkg::HDR_LEN + 7);

	// largest record that fits behind the page header
	assign psize = 19'd1 << cfg.shift;
	assign limit = psize - 19'(lrsa_pkg::FIRST_SLOT);

	always_comb begin
		geom.uoff  = {uoff_sum[16:3], 3'b000};
		geom.cdl   = cdl;
		geom.total = {total_sum[17:3], 3'b000};
		geom.full  = {1'b0, total_sum[17:3], 3'b000} > limit;
	end

endmodule

`default_nettype wire

@@ rtl/core/lrsa_place.sv @@
// ---------------------------------------------------------------------------
// lrsa_place: cursor placement and LSN
// Moves the cursor to the next page or wraps it when the record does not
// fit, then forms the byte offset, the LSN and the next cursor.
// ---------------------------------------------------------------------------
`default_nettype none

module lrsa_place (
	input  wire lrsa_pkg::cfg_t   cfg,
	input  wire lrsa_pkg::state_t cur,
	input  wire [17:0]            total,
	output lrsa_pkg::state_t      nxt,
	output lrsa_pkg::place_t      place
);

	logic [18:0] end_off;
	logic [18:0] psize;
	logic [16:0] page_inc;
	logic        move;
	logic        wrap;
	logic [15:0] new_page;
	logic [15:0] new_off;
	logic [18:0] next_end;
	logic [31:0] byte_off;
	logic [63:0] seq_new;
	logic [63:0] mask;

	assign psize   = 19'd1 << cfg.shift;
	assign end_off = {3'b000, cur.off} + {1'b0, total};

	// stale page or no room left: go to the next page, wrap past the image end
	assign move     = (cur.page >= cfg.count) || (end_off > psize);
	assign page_inc = {1'b0, cur.page} + 17'd1;
	assign wrap     = move && (page_inc >= {1'b0, cfg.count});

	always_comb begin
		priority if (wrap) begin
			new_page = lrsa_pkg::CURSOR_PAGE_RST;
		end else if (move) begin
			new_page = page_inc[15:0];
		end else begin
			new_page = cur.page;
		end
	end

	assign new_off  = move ? 16'(lrsa_pkg::FIRST_SLOT) : cur.off;
	assign next_end = {3'b000, new_off} + {1'b0, total};

	// image byte offset and LSN
	assign byte_off = ({16'd0, new_page} << cfg.shift) + {16'd0, new_off};
	assign seq_new  = cur.seq + {63'd0, wrap};
	assign mask     = (64'd1 << cfg.obits) - 64'd1;

	always_comb begin
		place.lsn      = (seq_new << cfg.obits) | ({35'd0, byte_off[31:3]} & mask);
		place.byte_off = byte_off;
		place.wrapped  = wrap;
		nxt.page       = new_page;
		nxt.off        = next_end[15:0];
		nxt.seq        = seq_new;
	end

endmodule

`default_nettype wire

@@ rtl/core/log_record_slot_allocator.sv @@
// ---------------------------------------------------------------------------
// log_record_slot_allocator: journal record slot allocator
// Places write-ahead log records in a circular page image and assigns LSNs.
// ---------------------------------------------------------------------------
// One request is taken per cycle while the result stream is not stalled. The
// request is held in an input register, geometry and placement are worked
// out combinationally against the write cursor, and the result lands in an
// output register that drives the result stream. The cursor update is a
// combinational loop (fit check, page step or wrap, sequence increment), so
// requests follow back to back at one per cycle while unstalled; a stalled
// result register holds one result while one more request waits in the input
// register. The user must write registers through the configuration port
// only while no request is in flight; the block does not enforce this.
`default_nettype none

module log_record_slot_allocator (
	input  wire                                clk,
	input  wire                                arst_n,
	lrsa_stream_if.sink                        req,
	lrsa_stream_if.source                      rsp,
	input  wire                                cfg_wr_en,
	input  wire [lrsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire [lrsa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [3:0]        page_shift_q;
	logic [15:0]       page_count_q;
	lrsa_pkg::cfg_t    cfg;

	logic              valid_s1;
	lrsa_pkg::req_t    req_s1;
	logic              rsp_valid_q;
	lrsa_pkg::rsp_t    rsp_q;

	lrsa_pkg::state_t  state_q;
	lrsa_pkg::state_t  state_nxt;
	lrsa_pkg::geom_t   geom;
	lrsa_pkg::place_t  place;

	logic              out_free;
	logic              fire_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= lrsa_pkg::PAGE_SHIFT_RST;
			page_count_q <= lrsa_pkg::PAGE_COUNT_RST;
		end else if (cfg_wr_en) begin
			unique case (lrsa_pkg::reg_index_t'(cfg_index))
				lrsa_pkg::REG_PAGE_SHIFT: page_shift_q <= cfg_wdata[3:0];
				lrsa_pkg::REG_PAGE_COUNT: page_count_q <= cfg_wdata[15:0];
			endcase
		end
	end

	assign cfg = lrsa_pkg::derive_cfg(page_shift_q, page_count_q);

	// flow control
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	lrsa_geometry u_geometry (
		.req  (req_s1),
		.cfg  (cfg),
		.geom (geom)
	);

	lrsa_place u_place (
		.cfg   (cfg),
		.cur   (state_q),
		.total (geom.total),
		.nxt   (state_nxt),
		.place (place)
	);

	// write cursor and sequence number; a refused record leaves them alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.page <= lrsa_pkg::CURSOR_PAGE_RST;
			state_q.off  <= lrsa_pkg::CURSOR_OFF_RST;
			state_q.seq  <= lrsa_pkg::SEQ_RST;
		end else if (fire_s1 && !geom.full) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q.client_data_length <= geom.cdl;
			rsp_q.undo_start         <= geom.uoff;
			rsp_q.total_length       <= geom.total;
			if (geom.full) begin
				rsp_q.status        <= lrsa_pkg::ST_LOG_FULL;
				rsp_q.lsn           <= 64'd0;
				rsp_q.record_offset <= 32'd0;
				rsp_q.wrapped       <= 1'b0;
			end else begin
				rsp_q.status        <= lrsa_pkg::ST_PLACED;
				rsp_q.lsn           <= place.lsn;
				rsp_q.record_offset <= place.byte_off;
				rsp_q.wrapped       <= place.wrapped;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// checks
	a_seq_only_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire_s1 && !geom.full && place.wrapped) |=> $stable(state_q.seq))
		else $error("sequence number changed without a wrap");

	a_page_in_data_area: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.page >= lrsa_pkg::CURSOR_PAGE_RST)
		else $error("cursor page points at a restart page");

	a_offset_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.off <= 16'h8000)
		else $error("cursor offset beyond the largest page");

	a_full_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status == lrsa_pkg::ST_LOG_FULL)
		|-> (rsp.data.lsn == 64'd0 && !rsp.data.wrapped))
		else $error("refused record carries placement data");

endmodule

`default_nettype wire
